// File: rtl/lnc_pkg.sv
// Package: types and constants shared by the name cache modules.
`default_nettype none
package lnc_pkg;
	localparam int WAYS_DEF = 32;
	localparam int MAX_NAME_LEN_DEF = 32;
	localparam logic [2:0] HIT_COST = 3'd1;
	localparam logic [2:0] MISS_COST = 3'd5;
	localparam logic [7:0] CASE_OFFSET = 8'd32;
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_Z = 8'h5a;

	typedef struct packed {
		logic [7:0] ch;
		logic last_char;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic [2:0] access_cost;
		logic [31:0] total_cost;
		logic name_too_long;
	} out_item_t;

	typedef struct packed {
		logic store_char;
		logic clr_name;
		logic scan_start;
		logic scan_step;
		logic ins_step;
		logic finish;
	} lnc_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic ins_done;
		logic need_insert;
	} lnc_sts_t;
endpackage
`default_nettype wire

// File: rtl/lnc_datapath.sv
// Datapath: name buffer, entry storage, sequential compare, LRU ranks, cost sum.
`default_nettype none
module lnc_datapath #(
	parameter int WAYS = lnc_pkg::WAYS_DEF,
	parameter int MAX_NAME_LEN = lnc_pkg::MAX_NAME_LEN_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [7:0] ch,
	input wire logic [5:0] cache_size,
	input wire lnc_pkg::lnc_cmd_t cmd,
	output lnc_pkg::lnc_sts_t sts,
	output lnc_pkg::out_item_t result
);
	import lnc_pkg::*;
	localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WC = $clog2(WAYS + 1);
	localparam int LB = $clog2(MAX_NAME_LEN);
	localparam int LW = $clog2(MAX_NAME_LEN + 1);
	localparam int AB = WB + LB;

	logic [7:0] nbuf_q [MAX_NAME_LEN];
	logic [7:0] mem_q [2**AB];
	logic [LW-1:0] elen_q [WAYS];
	logic [WAYS-1:0] valid_q;
	logic [WB-1:0] rank_q [WAYS];
	logic [LW-1:0] len_q;
	logic ovf_q;
	logic [31:0] sum_q;
	logic [WC-1:0] active;

	// scan state
	logic [WB-1:0] way_q;
	logic [LB-1:0] pos_q;
	logic [7:0] rd_q;
	logic rd_vld_q;
	logic [WB-1:0] rd_way_q;
	logic [LB-1:0] rd_pos_q;
	logic ok_q;
	logic found_q;
	logic [WB-1:0] hit_way_q;
	logic scan_done_q;
	logic have_inv_q;
	logic [WB-1:0] inv_way_q;
	logic [WB-1:0] old_way_q;
	logic [WB-1:0] old_rank_q;
	logic [LB-1:0] ins_pos_q;
	logic ins_done_q;
	logic [WB-1:0] tgt;
	logic [WB:0] next_way;
	logic [7:0] fch;

	assign active = ({1'b0, cache_size} > 7'(WAYS)) ? WC'(WAYS) : WC'(cache_size);
	assign fch = (ch >= CHAR_A && ch <= CHAR_Z) ? ch + CASE_OFFSET : ch;
	assign next_way = {1'b0, way_q} + 1'b1;
	assign tgt = have_inv_q ? inv_way_q : old_way_q;
	assign sts.scan_done = scan_done_q;
	assign sts.ins_done = ins_done_q;
	assign sts.need_insert = !found_q && !ovf_q && active != '0;

	always_ff @(posedge clk) begin
		if (cmd.store_char && len_q < LW'(MAX_NAME_LEN))
			nbuf_q[len_q[LB-1:0]] <= fch;
		rd_q <= mem_q[{way_q, pos_q}];
		if (cmd.ins_step)
			mem_q[AB'({tgt, ins_pos_q})] <= nbuf_q[ins_pos_q];
		if (cmd.ins_step && ins_pos_q == '0)
			elen_q[tgt] <= len_q;
	end

	// Scan reads one byte per cycle; a way is skipped early on length mismatch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			sum_q <= '0;
			valid_q <= '0;
			for (int i = 0; i < WAYS; i++) rank_q[i] <= WB'(i);
			way_q <= '0;
			pos_q <= '0;
			rd_vld_q <= 1'b0;
			rd_way_q <= '0;
			rd_pos_q <= '0;
			ok_q <= 1'b0;
			found_q <= 1'b0;
			hit_way_q <= '0;
			scan_done_q <= 1'b0;
			have_inv_q <= 1'b0;
			inv_way_q <= '0;
			old_way_q <= '0;
			old_rank_q <= '0;
			ins_pos_q <= '0;
			ins_done_q <= 1'b0;
			result <= '0;
		end else begin
			ins_done_q <= 1'b0;
			if (cmd.store_char) begin
				if (len_q < LW'(MAX_NAME_LEN)) len_q <= len_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.scan_start) begin
				way_q <= '0;
				pos_q <= '0;
				rd_vld_q <= 1'b0;
				ok_q <= 1'b1;
				found_q <= 1'b0;
				// the last character itself may overflow the buffer
				scan_done_q <= ovf_q || len_q == LW'(MAX_NAME_LEN) || active == '0;
				have_inv_q <= 1'b0;
				old_way_q <= '0;
				old_rank_q <= '0;
				ins_pos_q <= '0;
			end else if (cmd.scan_step && !scan_done_q) begin
				// issue next read
				rd_vld_q <= 1'b0;
				if (rd_vld_q) begin
					if (rd_q != nbuf_q[rd_pos_q]) ok_q <= 1'b0;
				end
				if (!rd_vld_q && pos_q == '0 && rd_pos_q == '0 && !ok_q) begin
					ok_q <= 1'b1;
				end
				if (pos_q == '0 && !rd_vld_q) begin
					// start of a way: bookkeeping
					if (!valid_q[way_q] && !have_inv_q) begin
						have_inv_q <= 1'b1;
						inv_way_q <= way_q;
					end
					if (rank_q[way_q] >= old_rank_q) begin
						old_rank_q <= rank_q[way_q];
						old_way_q <= way_q;
					end
					if (!valid_q[way_q] || elen_q[way_q] != len_q || len_q == '0) begin
						if (valid_q[way_q] && len_q == '0 && elen_q[way_q] == '0) begin
							found_q <= 1'b1;
							hit_way_q <= way_q;
							scan_done_q <= 1'b1;
						end else if (next_way >= (WB+1)'(active)) begin
							scan_done_q <= 1'b1;
						end else way_q <= next_way[WB-1:0];
					end else begin
						rd_vld_q <= 1'b1;
						rd_way_q <= way_q;
						rd_pos_q <= '0;
						ok_q <= 1'b1;
						pos_q <= pos_q + 1'b1;
						if (LW'(pos_q) + 1'b1 == len_q) pos_q <= '0;
					end
				end else if (rd_vld_q) begin
					// compare byte just read, continue or finish way
					if (rd_q == nbuf_q[rd_pos_q] && ok_q) begin
						if (LW'(rd_pos_q) + 1'b1 == len_q) begin
							found_q <= 1'b1;
							hit_way_q <= rd_way_q;
							scan_done_q <= 1'b1;
						end else begin
							rd_vld_q <= 1'b1;
							rd_pos_q <= rd_pos_q + 1'b1;
							pos_q <= pos_q + 1'b1;
						end
					end else begin
						pos_q <= '0;
						rd_pos_q <= '0;
						if (next_way >= (WB+1)'(active)) scan_done_q <= 1'b1;
						else way_q <= next_way[WB-1:0];
					end
				end
			end
			if (cmd.ins_step) begin
				ins_pos_q <= ins_pos_q + 1'b1;
				if (LW'(ins_pos_q) + 1'b1 >= len_q) ins_done_q <= 1'b1;
			end
			if (cmd.finish) begin
				logic [WB-1:0] e;
				logic [WB-1:0] old;
				logic [2:0] c;
				logic [32:0] s;
				e = found_q ? hit_way_q : tgt;
				old = rank_q[e];
				c = found_q ? HIT_COST : MISS_COST;
				if (found_q || sts.need_insert) begin
					for (int j = 0; j < WAYS; j++)
						if (rank_q[j] < old) rank_q[j] <= rank_q[j] + 1'b1;
					rank_q[e] <= '0;
					if (!found_q) valid_q[e] <= 1'b1;
				end
				s = {1'b0, sum_q} + 33'(c);
				sum_q <= s[32] ? '1 : s[31:0];
				result.hit <= found_q;
				result.access_cost <= c;
				result.total_cost <= s[32] ? '1 : s[31:0];
				result.name_too_long <= ovf_q;
				len_q <= '0;
				ovf_q <= 1'b0;
				scan_done_q <= 1'b0;
			end
			if (cmd.clr_name) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/lnc_ctrl.sv
// Controller: sequences capture, scan, insert and result delivery.
`default_nettype none
module lnc_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_last,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire lnc_pkg::lnc_sts_t sts,
	output lnc_pkg::lnc_cmd_t cmd
);
	import lnc_pkg::*;
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_INS, S_FIN, S_OUT} state_t;
	state_t state_q;
	logic acc;

	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && !in_stall;

	always_comb begin
		cmd = '0;
		cmd.store_char = acc;
		cmd.scan_start = acc && in_last;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.ins_step = (state_q == S_INS) && !sts.ins_done;
		cmd.finish = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (acc && in_last) state_q <= S_SCAN;
				S_SCAN: if (sts.scan_done)
					state_q <= sts.need_insert ? S_INS : S_FIN;
				S_INS: if (sts.ins_done) state_q <= S_FIN;
				S_FIN: begin
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/lru_name_cache_cost.sv
// Top level: case-insensitive fully associative LRU name cache with cost total.
// A name is taken one character per cycle. On its last character the cache is
// scanned one stored byte per cycle, skipping ways whose length differs; a miss
// on a name that fits, with a nonzero cache size, then writes the name into
// entry memory at one byte per cycle, and the result is held until taken; the next
// name is accepted after that. The byte-serial scan and insert set the rate.
`default_nettype none
module lru_name_cache_cost #(
	parameter int WAYS = lnc_pkg::WAYS_DEF,
	parameter int MAX_NAME_LEN = lnc_pkg::MAX_NAME_LEN_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire lnc_pkg::in_item_t in_item,
	output logic out_valid,
	input wire logic out_stall,
	output lnc_pkg::out_item_t out_item,
	input wire logic cfg_we,
	input wire logic [5:0] cfg_wdata
);
	import lnc_pkg::*;
	lnc_cmd_t cmd;
	lnc_sts_t sts;
	logic [5:0] size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= '0;
		else if (cfg_we) size_q <= cfg_wdata;
	end

	lnc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(in_item.last_char),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd)
	);

	lnc_datapath #(.WAYS(WAYS), .MAX_NAME_LEN(MAX_NAME_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .ch(in_item.ch), .cache_size(size_q),
		.cmd(cmd), .sts(sts), .result(out_item)
	);
endmodule
`default_nettype wire

// File: tb/sv/lru_name_cache_cost_tb.sv
// Testbench for the case-insensitive LRU name cache: predictor, driver and result checker.
`timescale 1ns / 1ps
`default_nettype none
module lru_name_cache_cost_tb;
	import lnc_pkg::*;

	localparam int WAYS = WAYS_DEF;
	localparam int MAXLEN = MAX_NAME_LEN_DEF;
	localparam int SETTLE = 2 * WAYS * (MAXLEN + 2) + 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;

	lru_name_cache_cost #(.WAYS(WAYS), .MAX_NAME_LEN(MAXLEN)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [7:0] cur_name [MAXLEN];
	int cur_len;
	bit cur_over;
	logic [7:0] way_chars [WAYS][MAXLEN];
	int way_len [WAYS];
	bit way_valid [WAYS];
	int way_rank [WAYS];
	logic [31:0] cost_total;
	logic [5:0] cache_size;

	in_item_t char_q[$];
	out_item_t lookup_q[$];
	int errors = 0;
	int n_results = 0;
	int n_hits = 0;
	int n_long = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_send = 1'b0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void promote(input int e);
		int old;
		old = way_rank[e];
		for (int j = 0; j < WAYS; j++)
			if (way_rank[j] < old) way_rank[j]++;
		way_rank[e] = 0;
	endfunction

	function automatic void predict_char(input in_item_t it);
		logic [7:0] c;
		int active, victim;
		bit found, same;
		out_item_t r;
		c = it.ch;
		if (c >= CHAR_A && c <= CHAR_Z) c = c + CASE_OFFSET;
		if (cur_len < MAXLEN) begin
			cur_name[cur_len] = c;
			cur_len++;
		end else begin
			cur_over = 1'b1;
		end
		if (!it.last_char) return;
		active = (cache_size > WAYS) ? WAYS : cache_size;
		found = 1'b0;
		if (!cur_over) begin
			for (int e = 0; e < active && !found; e++) begin
				if (way_valid[e] && way_len[e] == cur_len) begin
					same = 1'b1;
					for (int k = 0; k < cur_len; k++)
						if (way_chars[e][k] != cur_name[k]) same = 1'b0;
					if (same) begin
						found = 1'b1;
						promote(e);
					end
				end
			end
			if (!found && active > 0) begin
				victim = -1;
				for (int e = 0; e < active && victim < 0; e++)
					if (!way_valid[e]) victim = e;
				if (victim < 0) begin
					victim = 0;
					for (int e = 1; e < active; e++)
						if (way_rank[e] > way_rank[victim]) victim = e;
				end
				for (int k = 0; k < cur_len; k++) way_chars[victim][k] = cur_name[k];
				way_len[victim] = cur_len;
				way_valid[victim] = 1'b1;
				promote(victim);
			end
		end
		r.hit = found;
		r.access_cost = found ? HIT_COST : MISS_COST;
		if (cost_total > 32'hFFFF_FFFF - r.access_cost) cost_total = 32'hFFFF_FFFF;
		else cost_total = cost_total + r.access_cost;
		r.total_cost = cost_total;
		r.name_too_long = cur_over;
		lookup_q = {lookup_q, r};
		cur_len = 0;
		cur_over = 1'b0;
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_char(in_item);
		end
		if (!in_valid || !in_stall) begin
			if (char_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
				in_item <= char_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (lookup_q.size() == 0) begin
				report("unexpected result", 64'(out_item), 64'(0));
			end else begin
				out_item_t w;
				w = lookup_q.pop_front();
				if (out_item.hit !== w.hit) report("hit", 64'(out_item.hit), 64'(w.hit));
				if (out_item.access_cost !== w.access_cost)
					report("access_cost", 64'(out_item.access_cost), 64'(w.access_cost));
				if (out_item.total_cost !== w.total_cost)
					report("total_cost", 64'(out_item.total_cost), 64'(w.total_cost));
				if (out_item.name_too_long !== w.name_too_long)
					report("name_too_long", 64'(out_item.name_too_long),
						64'(w.name_too_long));
				n_results++;
				if (w.hit) n_hits++;
				if (w.name_too_long) n_long++;
			end
		end
	end

	function automatic logic [7:0] rand_char();
		int p;
		p = $urandom_range(9);
		if (p < 4) return 8'h61 + 8'($urandom_range(2));
		if (p < 7) return 8'h41 + 8'($urandom_range(2));
		return 8'($urandom_range(255));
	endfunction

	task automatic push_name(input logic [7:0] s [$]);
		in_item_t it;
		for (int k = 0; k < s.size(); k++) begin
			it.ch = s[k];
			it.last_char = (k == s.size() - 1);
			char_q = {char_q, it};
		end
	endtask

	task automatic push_random_name(input int maxlen);
		logic [7:0] s [$];
		int n;
		n = $urandom_range(maxlen, 1);
		for (int k = 0; k < n; k++) s = {s, rand_char()};
		push_name(s);
	endtask

	task automatic drain();
		while (char_q.size() > 0) @(posedge clk);
		@(posedge clk);
		while (in_valid || lookup_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(input logic [5:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cache_size = v;
	endtask

	initial begin
		logic [7:0] s [$];
		logic [5:0] sizes [6];
		cur_len = 0;
		cur_over = 1'b0;
		cost_total = '0;
		cache_size = '0;
		for (int i = 0; i < WAYS; i++) begin
			way_valid[i] = 1'b0;
			way_rank[i] = i;
			way_len[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: size zero, then full size with case folding, long names
		s = {8'h41, 8'h62};
		push_name(s);
		push_name(s);
		drain();
		write_size(6'd32);
		s = {8'h41, 8'h5A, 8'h40, 8'h5B, 8'h00, 8'hFF};
		push_name(s);
		s = {8'h61, 8'h7A, 8'h40, 8'h5B, 8'h00, 8'hFF};
		push_name(s);
		s = {8'h60};
		push_name(s);
		s = {8'h7B};
		push_name(s);
		s = {};
		for (int k = 0; k < MAXLEN; k++) s = {s, 8'h80 + 8'(k)};
		push_name(s);
		push_name(s);
		s = {s, 8'h55};
		push_name(s);
		drain();

		// first pass with the sender held back while the names are queued, then released
		hold_send = 1'b1;
		for (int n = 0; n < 40; n++) push_random_name(6);
		repeat (50) @(posedge clk);
		hold_send = 1'b0;
		drain();

		sizes = '{6'd1, 6'd63, 6'd4, 6'd0, 6'd2, 6'd32};
		for (int ph = 0; ph < 24; ph++) begin
			write_size(sizes[ph % 6]);
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 82; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 82; end
				default: begin send_idle = 18; recv_stall = 18; end
			endcase
			for (int n = 0; n < 14; n++) begin
				if ($urandom_range(19) == 0) push_random_name(MAXLEN + 4);
				else push_random_name(3);
			end
			drain();
		end
		send_idle = 0;
		recv_stall = 0;
		$display("ran %0d lookups over several cache sizes: %0d hits, %0d overlong names",
			n_results, n_hits, n_long);
		if (errors == 0) $display("lru_name_cache_cost_tb passed");
		else $display("lru_name_cache_cost_tb failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("lru_name_cache_cost_tb failed");
		$finish;
	end
endmodule
`default_nettype wire
